>>> design/longest_prefix_route_table_unit_defines.svh
// Assertion macros for the route table unit.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_UNIT_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_UNIT_DEFINES_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define LPRT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define LPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lprt_pkg.sv
`default_nettype none

package lprt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam logic [31:0] ADDR_ONES = 32'hFFFF_FFFF;
  localparam logic [5:0]  LEN_MAX   = 6'd32;

  // result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_ADDED    = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } lprt_state_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic        hop_flag;
    logic [31:0] hop_addr;
    logic [2:0]  port;
  } route_entry_t;

  // network mask for a prefix length of 0..32
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len != 6'd0) begin
      m = ADDR_ONES << (LEN_MAX - len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> design/longest_prefix_route_table_unit.sv
`default_nettype none

// IPv4 route table with longest-prefix match, TABLE_DEPTH slots held in one
// single-port-read / single-port-write synchronous RAM plus a row of valid
// flops (cleared at reset, so the table is empty right away). Raise start for
// one cycle while busy is low to hand in a word: in_mode = 0 looks up
// in_dest_addr, in_mode = 1 adds (or replaces) a route. Every word yields
// exactly one result word, shown for a single cycle with out_valid high; the
// receiver cannot stall it, so it must take it in that cycle. From accept to
// result the unit reads the RAM once per slot, finishes the last compare,
// then writes an added route back and registers the result. busy drops in
// the cycle the result is shown, so the next word may be started then.
// Prefixes are stored unmasked, so set host bits keep a route from ever
// matching; lengths above 32 are taken as 32.
module longest_prefix_route_table_unit
  import lprt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command side
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_dest_addr,
  input  wire logic [31:0] in_net_prefix,
  input  wire logic [5:0]  in_prefix_len,
  input  wire logic        in_hop_present,
  input  wire logic [31:0] in_hop_addr,
  input  wire logic [2:0]  in_out_port,
  // result side
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [2:0]       out_port_chosen,
  output logic             out_hop_given,
  output logic [31:0]      out_forward_addr,
  output logic [5:0]       out_match_len
);

`include "longest_prefix_route_table_unit_defines.svh"

  // ---------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------
  lprt_state_t state_r, state_nxt;
  logic        accept;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r;
  logic        cmp_vld_r;
  logic        rd_last;

  assign accept  = start && !busy;
  assign rd_last = (rd_idx_r == IDX_W'(TABLE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_vld_r <= (state_r == S_SCAN);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    busy       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt  = S_SCAN;
          rd_idx_nxt = '0;
        end
      end
      S_SCAN: begin
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // compare index: the read index registered alongside the RAM read
  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
  end

  // ---------------------------------------------------------------------
  // captured command word
  // ---------------------------------------------------------------------
  logic        mode_r;
  logic [31:0] dest_r;
  logic [31:0] pfx_r;
  logic [5:0]  plen_r;
  logic        hflag_r;
  logic [31:0] haddr_r;
  logic [2:0]  port_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      dest_r  <= in_dest_addr;
      pfx_r   <= in_net_prefix;
      plen_r  <= (in_prefix_len > LEN_MAX) ? LEN_MAX : in_prefix_len;
      hflag_r <= in_hop_present;
      haddr_r <= in_hop_present ? in_hop_addr : 32'd0;
      port_r  <= in_out_port;
    end
  end

  // ---------------------------------------------------------------------
  // table storage: payload RAM + valid flops
  // Writes happen only in S_FINISH; only reads made in S_SCAN are compared,
  // and a new word cannot start before the write, so none overlaps a write.
  // ---------------------------------------------------------------------
  route_entry_t            mem [TABLE_DEPTH];
  route_entry_t            mem_rd_r;
  route_entry_t            wr_entry;
  logic [TABLE_DEPTH-1:0]  valid_r;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;

  assign wr_entry = '{prefix: pfx_r, length: plen_r, hop_flag: hflag_r,
                      hop_addr: haddr_r, port: port_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    mem_rd_r <= mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // scan compare: one slot per cycle
  // ---------------------------------------------------------------------
  logic             ent_vld;
  logic             same_found_r, free_found_r, best_found_r;
  logic [IDX_W-1:0] same_idx_r, free_idx_r;
  logic [5:0]       best_len_r;
  logic [2:0]       best_port_r;
  logic             best_hflag_r;
  logic [31:0]      best_haddr_r;
  logic             take_same, take_free, take_best;

  assign ent_vld = valid_r[cmp_idx_r];

  always_comb begin
    take_same = 1'b0;
    take_free = 1'b0;
    take_best = 1'b0;
    if (cmp_vld_r) begin
      if (mode_r) begin
        take_same = ent_vld && !same_found_r && (mem_rd_r.prefix == pfx_r)
                    && (mem_rd_r.length == plen_r);
        take_free = !ent_vld && !free_found_r;
      end else begin
        // strictly longer wins: the lowest slot keeps a tie
        take_best = ent_vld
                    && (mem_rd_r.prefix == (dest_r & len_mask(mem_rd_r.length)))
                    && (!best_found_r || (mem_rd_r.length > best_len_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      same_found_r <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (accept) begin
      same_found_r <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else begin
      if (take_same) same_found_r <= 1'b1;
      if (take_free) free_found_r <= 1'b1;
      if (take_best) best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_same) same_idx_r <= cmp_idx_r;
    if (take_free) free_idx_r <= cmp_idx_r;
    if (take_best) begin
      best_len_r   <= mem_rd_r.length;
      best_port_r  <= mem_rd_r.port;
      best_hflag_r <= mem_rd_r.hop_flag;
      best_haddr_r <= mem_rd_r.hop_addr;
    end
  end

  // ---------------------------------------------------------------------
  // finish: write back on add, build result word
  // ---------------------------------------------------------------------
  assign wr_en  = (state_r == S_FINISH) && mode_r && (same_found_r || free_found_r);
  assign wr_idx = same_found_r ? same_idx_r : free_idx_r;

  logic        res_valid_r;
  logic [2:0]  res_status_r;
  logic [2:0]  res_port_r;
  logic        res_hop_r;
  logic [31:0] res_fwd_r;
  logic [5:0]  res_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= (state_r == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH) begin
      res_port_r <= 3'd0;
      res_hop_r  <= 1'b0;
      res_fwd_r  <= 32'd0;
      res_len_r  <= 6'd0;
      if (mode_r) begin
        if (same_found_r) begin
          res_status_r <= ST_REPLACED;
        end else if (free_found_r) begin
          res_status_r <= ST_ADDED;
        end else begin
          res_status_r <= ST_FULL;
        end
      end else if (best_found_r) begin
        res_status_r <= ST_HIT;
        res_port_r   <= best_port_r;
        res_hop_r    <= best_hflag_r;
        res_fwd_r    <= best_hflag_r ? best_haddr_r : dest_r;
        res_len_r    <= best_len_r;
      end else begin
        res_status_r <= ST_MISS;
        res_fwd_r    <= dest_r;
      end
    end
  end

  assign out_valid        = res_valid_r;
  assign out_status       = res_status_r;
  assign out_port_chosen  = res_port_r;
  assign out_hop_given    = res_hop_r;
  assign out_forward_addr = res_fwd_r;
  assign out_match_len    = res_len_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `LPRT_ASSERT_NEXT(a_accept_busy, accept, busy && !out_valid, "accept did not start a scan")
  `LPRT_ASSERT_NEXT(a_finish_result, state_r == S_FINISH, out_valid && !busy, "no result")
  `LPRT_ASSERT_SAME(a_one_source, wr_en, !(take_same || take_free || take_best), "write in compare")
  `LPRT_ASSERT_SAME(a_hit_len, out_valid && (out_status == ST_HIT), out_match_len <= LEN_MAX, "len")

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

// Route table unit bench.
// A behavioral copy of the route table predicts the result word for every
// command word at the edge where the unit accepts it. A monitor compares
// each result word, field by field, with the oldest prediction.
// Stimulus order:
//   1. Directed words: default route, nested prefixes, host bits set,
//      length saturation, replace, and the hop-absent case.
//   2. Random adds and lookups, built mostly from routes already in the table.
//   3. Overflow: fresh routes until the table is full, then dropped adds.
module tb;
  import lprt_pkg::*;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ADD    = 1'b1;
  localparam int   CYCLE_LIMIT = 900_000;
  localparam int   REPORT_MAX  = 10;

  // one command word as the sender sees it
  typedef struct packed {
    logic        mode;
    logic [31:0] dest_addr;
    logic [31:0] net_prefix;
    logic [5:0]  prefix_len;
    logic        hop_present;
    logic [31:0] hop_addr;
    logic [2:0]  out_port;
  } route_cmd_t;

  // one result word; the field order matches the concatenation in the monitor
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  port_chosen;
    logic        hop_given;
    logic [31:0] forward_addr;
    logic [5:0]  match_len;
  } route_reply_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        start            = 1'b0;
  logic        in_mode          = 1'b0;
  logic [31:0] in_dest_addr     = '0;
  logic [31:0] in_net_prefix    = '0;
  logic [5:0]  in_prefix_len    = '0;
  logic        in_hop_present   = 1'b0;
  logic [31:0] in_hop_addr      = '0;
  logic [2:0]  in_out_port      = '0;
  logic        busy;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [2:0]  out_port_chosen;
  logic        out_hop_given;
  logic [31:0] out_forward_addr;
  logic [5:0]  out_match_len;

  longest_prefix_route_table_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_dest_addr     (in_dest_addr),
    .in_net_prefix    (in_net_prefix),
    .in_prefix_len    (in_prefix_len),
    .in_hop_present   (in_hop_present),
    .in_hop_addr      (in_hop_addr),
    .in_out_port      (in_out_port),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_port_chosen  (out_port_chosen),
    .out_hop_given    (out_hop_given),
    .out_forward_addr (out_forward_addr),
    .out_match_len    (out_match_len)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow route table. Slots fill lowest-first and are never freed, so the
  // valid slots are always 0 .. routes_held-1.
  // ---------------------------------------------------------------------------
  logic         slot_used  [TABLE_DEPTH];
  route_entry_t route_slot [TABLE_DEPTH];
  int           routes_held = 0;

  route_reply_t pending_replies[$];
  int           tally[5];          // predicted words per status code
  int           words_sent   = 0;
  int           words_seen   = 0;
  int           mismatches   = 0;
  int           cycle_count  = 0;
  bit           steady_sender = 1'b0;

  route_reply_t seen_reply;
  route_reply_t want_reply;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < 5; i++) tally[i] = 0;
  end

  function automatic logic [31:0] net_mask(input logic [5:0] len);
    // len is already clipped to 0..32; a shift by 32 clears everything
    return ~(ADDR_ONES >> len);
  endfunction

  function automatic logic [5:0] clip_len(input logic [5:0] len);
    return (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // Apply one accepted word to the shadow table and return its result word.
  function automatic route_reply_t route_table_apply(input route_cmd_t c);
    route_reply_t r;
    logic [5:0]   len;
    int           i;
    int           same_slot;
    int           free_slot;
    int           best_slot;
    logic [5:0]   best_len;
    r = '0;
    len = clip_len(c.prefix_len);
    if (c.mode == MODE_ADD) begin
      same_slot = -1;
      free_slot = -1;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (slot_used[i]) begin
          if (same_slot < 0 && route_slot[i].prefix == c.net_prefix &&
              route_slot[i].length == len)
            same_slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (same_slot >= 0) begin
        i = same_slot;
        r.status = ST_REPLACED;
      end else if (free_slot >= 0) begin
        i = free_slot;
        r.status = ST_ADDED;
        routes_held++;
      end else begin
        r.status = ST_FULL;
        return r;
      end
      slot_used[i]           = 1'b1;
      route_slot[i].prefix   = c.net_prefix;
      route_slot[i].length   = len;
      route_slot[i].hop_flag = c.hop_present;
      route_slot[i].hop_addr = c.hop_present ? c.hop_addr : 32'd0;
      route_slot[i].port     = c.out_port;
      return r;
    end
    // lookup: strictly longer length wins, ties keep the lower slot
    best_slot = -1;
    best_len  = '0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_used[i] &&
          route_slot[i].prefix == (c.dest_addr & net_mask(route_slot[i].length)) &&
          (best_slot < 0 || route_slot[i].length > best_len)) begin
        best_slot = i;
        best_len  = route_slot[i].length;
      end
    end
    if (best_slot < 0) begin
      r.status       = ST_MISS;
      r.forward_addr = c.dest_addr;
    end else begin
      r.status       = ST_HIT;
      r.port_chosen  = route_slot[best_slot].port;
      r.hop_given    = route_slot[best_slot].hop_flag;
      r.forward_addr = route_slot[best_slot].hop_flag ?
                       route_slot[best_slot].hop_addr : c.dest_addr;
      r.match_len    = best_len;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Word generators. Unused fields always carry random junk.
  // ---------------------------------------------------------------------------
  function automatic route_cmd_t random_word();
    route_cmd_t c;
    c.mode         = 1'($urandom);
    c.dest_addr    = $urandom;
    c.net_prefix   = $urandom;
    c.prefix_len   = 6'($urandom_range(0, 63));
    c.hop_present  = 1'($urandom);
    c.hop_addr     = $urandom;
    c.out_port     = 3'($urandom);
    return c;
  endfunction

  function automatic route_cmd_t random_add_word();
    route_cmd_t c;
    int         pick;
    int         k;
    logic [5:0] len;
    c = random_word();
    c.mode = MODE_ADD;
    pick = $urandom_range(0, 99);
    k = (routes_held != 0) ? $urandom_range(0, routes_held - 1) : 0;
    if (routes_held != 0 && pick < 35) begin
      // same prefix and length as a held route -> replace
      c.net_prefix = route_slot[k].prefix;
      c.prefix_len = route_slot[k].length;
      if (c.prefix_len == LEN_MAX && $urandom_range(0, 3) == 0)
        c.prefix_len = 6'($urandom_range(33, 63));
      return c;
    end
    len = 6'($urandom_range(0, 32));
    if (routes_held != 0 && pick < 75) begin
      // nest above or below a held route
      c.net_prefix = (route_slot[k].prefix |
                      ($urandom & ~net_mask(route_slot[k].length))) & net_mask(len);
    end else begin
      c.net_prefix = $urandom & net_mask(len);
    end
    // some routes carry host bits and can never match
    if ($urandom_range(0, 99) < 15)
      c.net_prefix |= $urandom & ~net_mask(len);
    c.prefix_len = (len == LEN_MAX && $urandom_range(0, 3) == 0) ?
                   6'($urandom_range(33, 63)) : len;
    return c;
  endfunction

  function automatic route_cmd_t random_lookup_word();
    route_cmd_t c;
    int         pick;
    int         k;
    logic [5:0] len;
    c = random_word();
    c.mode = MODE_LOOKUP;
    pick = $urandom_range(0, 99);
    if (routes_held != 0 && pick < 60) begin
      k = $urandom_range(0, routes_held - 1);
      len = route_slot[k].length;
      c.dest_addr = (route_slot[k].prefix & net_mask(len)) | ($urandom & ~net_mask(len));
    end else if (pick >= 85) begin
      case ($urandom_range(0, 2))
        0:       c.dest_addr = 32'h0000_0000;
        1:       c.dest_addr = ADDR_ONES;
        default: c.dest_addr = $urandom & 32'hFF00_0000;
      endcase
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Fields change at the falling edge; a word is taken at the rising
  // edge where start is high and busy is low. The prediction is made right
  // there, so table order always follows acceptance order.
  // ---------------------------------------------------------------------------
  task automatic issue_word(input route_cmd_t c);
    route_reply_t r;
    @(negedge clk);
    start           <= 1'b1;
    in_mode         <= c.mode;
    in_dest_addr    <= c.dest_addr;
    in_net_prefix   <= c.net_prefix;
    in_prefix_len   <= c.prefix_len;
    in_hop_present  <= c.hop_present;
    in_hop_addr     <= c.hop_addr;
    in_out_port     <= c.out_port;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    r = route_table_apply(c);
    tally[r.status]++;
    words_sent++;
    pending_replies.push_back(r);
  endtask

  // hold start low for the requested pause; the idle fields wiggle so nothing leaks in
  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start        <= 1'b0;
      in_mode      <= 1'($urandom);
      in_dest_addr <= $urandom;
    end
  endtask

  // random gaps land before, during and after the table scan
  task automatic maybe_pause();
    if (!steady_sender && $urandom_range(0, 99) < 29)
      pause_sender($urandom_range(1, 80));
  endtask

  task automatic send_add(input logic [31:0] prefix, input logic [5:0] len,
                          input logic hop, input logic [31:0] hop_addr,
                          input logic [2:0] port);
    route_cmd_t c;
    c = random_word();
    c.mode         = MODE_ADD;
    c.net_prefix   = prefix;
    c.prefix_len   = len;
    c.hop_present  = hop;
    c.hop_addr     = hop_addr;
    c.out_port     = port;
    maybe_pause();
    issue_word(c);
  endtask

  task automatic send_lookup(input logic [31:0] dest);
    route_cmd_t c;
    c = random_word();
    c.mode      = MODE_LOOKUP;
    c.dest_addr = dest;
    maybe_pause();
    issue_word(c);
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor. Results cannot be held off, so every strobe is a word.
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[tb] %s at cycle %0d: want st=%0d port=%0d hop=%0d fwd=%h len=%0d, got st=%0d port=%0d hop=%0d fwd=%h len=%0d",
               what, cycle_count, want_reply.status, want_reply.port_chosen,
               want_reply.hop_given, want_reply.forward_addr, want_reply.match_len,
               seen_reply.status, seen_reply.port_chosen, seen_reply.hop_given,
               seen_reply.forward_addr, seen_reply.match_len);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      seen_reply = {out_status, out_port_chosen, out_hop_given, out_forward_addr,
                    out_match_len};
      want_reply = '0;
      if (out_valid !== 1'b1) begin
        log_mismatch("unknown result strobe");
      end else if (pending_replies.size() == 0) begin
        log_mismatch("result word with nothing pending");
      end else begin
        want_reply = pending_replies.pop_front();
        words_seen++;
        if (seen_reply !== want_reply)
          log_mismatch("result word differs");
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[tb] timeout after %0d cycles, %0d results pending",
               cycle_count, pending_replies.size());
      $display("longest_prefix_route_table_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_lookup(32'h0000_0000);                          // empty table: miss
    send_lookup(ADDR_ONES);
    send_add(32'h0000_0000, 6'd0, 1'b0, ADDR_ONES, 3'd7); // default route, hop ignored
    send_lookup(32'hC0A8_0101);                          // hits the default
    send_add(32'h0A00_0000, 6'd8, 1'b1, ADDR_ONES, 3'd1);
    send_add(32'h0A01_0000, 6'd16, 1'b0, 32'h1234_5678, 3'd2);
    send_add(32'h0A01_0203, 6'd32, 1'b1, 32'h0000_0000, 3'd3);
    send_add(32'hC0A8_0101, 6'd24, 1'b1, 32'h0A0A_0A0A, 3'd4); // host bits set
    send_add(ADDR_ONES, 6'd63, 1'b1, 32'h0101_0101, 3'd5); // saturates to 32
    send_add(ADDR_ONES, 6'd32, 1'b0, 32'h5555_AAAA, 3'd6); // same route: replace
    send_add(32'h0A00_0000, 6'd8, 1'b1, 32'h0102_0304, 3'd0); // replace /8
    send_add(32'h8000_0000, 6'd1, 1'b1, 32'hAAAA_5555, 3'd2);
    send_add(32'h0A01_0203, 6'd40, 1'b0, ADDR_ONES, 3'd3); // 40 replaces the /32
    send_lookup(32'h0A01_0203);                          // /32
    send_lookup(32'h0A01_09FF);                          // /16
    send_lookup(32'h0AC8_0001);                          // /8
    send_lookup(32'h0B00_0000);                          // default
    send_lookup(32'hC0A8_0101);                          // /1, the /24 is dead
    send_lookup(ADDR_ONES);                              // /32
    send_lookup(32'h7FFF_FFFF);                          // default
    send_add(32'h0000_0001, 6'd0, 1'b1, 32'h0F0F_0F0F, 3'd1); // length 0 with host bit
    send_lookup(32'h0000_0000);
    send_add(32'h0000_0000, 6'd0, 1'b1, 32'hF0F0_F0F0, 3'd1); // replace default
    send_lookup(32'h1234_5678);
    send_lookup(32'hC0A8_0100);
  endtask

  task automatic test_random_traffic(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      // one long run with start never dropped between words
      steady_sender = (n >= 500 && n < 700);
      maybe_pause();
      if ($urandom_range(0, 99) < 35)
        issue_word(random_add_word());
      else
        issue_word(random_lookup_word());
    end
    steady_sender = 1'b0;
  endtask

  // fill any free slots with fresh /32 routes, then keep adding until drops
  // show up; other random adds and lookups are mixed in along the way
  task automatic test_table_overflow();
    int         dropped_before;
    int         n;
    route_cmd_t c;
    dropped_before = tally[ST_FULL];
    n = 0;
    while (tally[ST_FULL] < dropped_before + 8 && n < 160) begin
      c = random_word();
      c.mode       = MODE_ADD;
      c.prefix_len = ($urandom_range(0, 1) == 0) ? LEN_MAX : 6'($urandom_range(33, 63));
      maybe_pause();
      issue_word(c);
      if (n % 4 == 3) begin
        maybe_pause();
        issue_word(random_add_word());
      end
      if (n % 3 == 0) begin
        maybe_pause();
        issue_word(random_lookup_word());
      end
      n++;
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    test_directed();
    test_random_traffic(1510);
    test_table_overflow();
    pause_sender(1);

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("[tb] %0d words sent, %0d results checked: %0d hit, %0d miss, %0d added, %0d replaced, %0d dropped",
             words_sent, words_seen, tally[ST_HIT], tally[ST_MISS], tally[ST_ADDED],
             tally[ST_REPLACED], tally[ST_FULL]);
    $display("[tb] %0d of %0d slots held at the end, %0d bad result words",
             routes_held, TABLE_DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("longest_prefix_route_table_unit: match");
    end else begin
      $display("longest_prefix_route_table_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
